// ----- design/pfa_pkg.sv -----
// Shared constants, types and codes for the packed field array.
`timescale 1ns / 1ps
`default_nettype none
package pfa_pkg;

    // Geometry of the store
    localparam int ELEMENT_BITS  = 5;
    localparam int WORD_BITS     = 32;
    localparam int ELEMENT_COUNT = 4096;
    localparam int INDEX_BITS    = 12;

    // One spare word so that the word above the last element's low word is always in range
    localparam int WORD_COUNT    = ELEMENT_COUNT * ELEMENT_BITS / WORD_BITS + 1;

    // Words are split over two banks: even words and odd words
    localparam int BANK_DEPTH    = (WORD_COUNT + 1) / 2;
    localparam int BANK_AW       = $clog2(BANK_DEPTH);

    // Bit position of an element and its split into word index and offset
    localparam int POS_BITS      = $clog2(ELEMENT_COUNT * ELEMENT_BITS);
    localparam int SHIFT_BITS    = $clog2(WORD_BITS);
    localparam int WIDX_BITS     = POS_BITS - SHIFT_BITS;

    // Operation codes
    localparam logic FUNC_READ   = 1'b0;
    localparam logic FUNC_WRITE  = 1'b1;

    typedef logic [WORD_BITS-1:0]    word_t;
    typedef logic [BANK_AW-1:0]      bank_addr_t;
    typedef logic [ELEMENT_BITS-1:0] elem_t;
    typedef logic [SHIFT_BITS-1:0]   shift_t;

    // Control carried with an access from issue to merge
    typedef struct packed {
        logic   is_write;
        logic   in_range;
        logic   lo_odd;    // low word of the element sits in the odd bank
        logic   crosses;   // element spills into the next word
        shift_t offset;    // bit offset of the element in its low word
        elem_t  value;
    } acc_info_t;

endpackage
`default_nettype wire

// ----- design/packed_field_array.sv -----
// Packed field array top level: issue, two word banks, merge and result register.
// Access and bank read data are registered, then a read moves into the result register.
// Throughput: one word per cycle, reads and writes alike, unless a read waits for the
// result register; the even and odd word banks serve both halves of a straddling element
// together; a write in the second stage is forwarded to the next access of the same word.
// Reset: a clearing pass zeroes all BANK_DEPTH (321) words of each bank with s_ready low.
`timescale 1ns / 1ps
`default_nettype none
module packed_field_array (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire                s_func,
    input  wire [11:0]         s_elem_index,
    input  wire pfa_pkg::elem_t s_write_value,
    output logic               m_valid,
    input  wire                m_ready,
    output pfa_pkg::elem_t     m_read_value
);
    import pfa_pkg::*;

    // Clearing pass
    logic       clr_reg,      clr_next;
    bank_addr_t clr_addr_reg, clr_addr_next;

    // Second stage (banks read, merge in progress)
    logic       s1_valid_reg, s1_valid_next;
    acc_info_t  s1_info_reg;
    bank_addr_t s1_addr_e_reg, s1_addr_o_reg;

    // Forwarding of a write that lands while the next access reads
    logic       fwd_e_reg, fwd_o_reg;
    word_t      fwd_e_data_reg, fwd_o_data_reg;

    // Result register
    logic       out_valid_reg, out_valid_next;
    elem_t      out_data_reg;

    // Issue side
    logic [POS_BITS-1:0]  pos;
    logic [WIDX_BITS-1:0] widx;
    bank_addr_t           addr_e, addr_o;
    acc_info_t            info_in;
    logic                 accept;

    // Merge side
    word_t      even_q, odd_q, even_word, odd_word, new_even, new_odd;
    elem_t      merged_value;
    logic       s1_adv, s1_rd_adv;
    logic       we_e, we_o;
    logic       bank_we_e, bank_we_o;
    bank_addr_t bank_wa_e, bank_wa_o;
    word_t      bank_wd_e, bank_wd_o;

    // Address and offset of the element
    assign pos    = POS_BITS'(s_elem_index) * POS_BITS'(ELEMENT_BITS);
    assign widx   = pos[POS_BITS-1:SHIFT_BITS];
    assign addr_o = widx[WIDX_BITS-1:1];
    assign addr_e = widx[WIDX_BITS-1:1] + BANK_AW'(widx[0]);

    always_comb begin
        info_in.is_write = (s_func == FUNC_WRITE);
        info_in.in_range = ({1'b0, s_elem_index} < (INDEX_BITS+1)'(ELEMENT_COUNT));
        info_in.lo_odd   = widx[0];
        info_in.offset   = pos[SHIFT_BITS-1:0];
        info_in.crosses  = ({1'b0, pos[SHIFT_BITS-1:0]} + (SHIFT_BITS+1)'(ELEMENT_BITS))
                           > (SHIFT_BITS+1)'(WORD_BITS);
        info_in.value    = s_write_value;
    end

    // Handshake: a write always retires, a read retires into a free result register
    assign s1_adv    = s1_valid_reg && (s1_info_reg.is_write || !out_valid_reg || m_ready);
    assign s1_rd_adv = s1_adv && !s1_info_reg.is_write;
    assign s_ready   = !clr_reg && (!s1_valid_reg || s1_adv);
    assign accept    = s_valid && s_ready;

    // Word banks
    pfa_bank u_bank_even (
        .aclk    (aclk),
        .wr_en   (bank_we_e),
        .wr_addr (bank_wa_e),
        .wr_data (bank_wd_e),
        .rd_en   (accept),
        .rd_addr (addr_e),
        .rd_data (even_q)
    );

    pfa_bank u_bank_odd (
        .aclk    (aclk),
        .wr_en   (bank_we_o),
        .wr_addr (bank_wa_o),
        .wr_data (bank_wd_o),
        .rd_en   (accept),
        .rd_addr (addr_o),
        .rd_data (odd_q)
    );

    // Forwarded words replace stale read data
    assign even_word = fwd_e_reg ? fwd_e_data_reg : even_q;
    assign odd_word  = fwd_o_reg ? fwd_o_data_reg : odd_q;

    pfa_merge u_merge (
        .info       (s1_info_reg),
        .even_word  (even_word),
        .odd_word   (odd_word),
        .read_value (merged_value),
        .new_even   (new_even),
        .new_odd    (new_odd)
    );

    // Write-back: the low word always, the high word only when the element straddles
    assign we_e = s1_valid_reg && s1_info_reg.is_write && s1_info_reg.in_range
                  && (!s1_info_reg.lo_odd || s1_info_reg.crosses);
    assign we_o = s1_valid_reg && s1_info_reg.is_write && s1_info_reg.in_range
                  && (s1_info_reg.lo_odd || s1_info_reg.crosses);

    assign bank_we_e = clr_reg || we_e;
    assign bank_we_o = clr_reg || we_o;
    assign bank_wa_e = clr_reg ? clr_addr_reg : s1_addr_e_reg;
    assign bank_wa_o = clr_reg ? clr_addr_reg : s1_addr_o_reg;
    assign bank_wd_e = clr_reg ? '0 : new_even;
    assign bank_wd_o = clr_reg ? '0 : new_odd;

    // Next-state logic for control
    always_comb begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg) begin
            if (clr_addr_reg == BANK_AW'(BANK_DEPTH - 1)) begin
                clr_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + BANK_AW'(1);
            end
        end

        s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

        out_valid_next = out_valid_reg;
        if (s1_rd_adv) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_e_reg     <= 1'b0;
            fwd_o_reg     <= 1'b0;
        end else begin
            clr_reg       <= clr_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept) begin
                fwd_e_reg <= we_e && (s1_addr_e_reg == addr_e);
                fwd_o_reg <= we_o && (s1_addr_o_reg == addr_o);
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_info_reg    <= info_in;
            s1_addr_e_reg  <= addr_e;
            s1_addr_o_reg  <= addr_o;
            fwd_e_data_reg <= new_even;
            fwd_o_data_reg <= new_odd;
        end
        if (s1_rd_adv) begin
            out_data_reg <= merged_value;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_read_value = out_data_reg;

endmodule
`default_nettype wire

// ----- design/pfa_bank.sv -----
// One bank of word storage: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none
module pfa_bank (
    input  wire                  aclk,
    input  wire                  wr_en,
    input  wire pfa_pkg::bank_addr_t wr_addr,
    input  wire pfa_pkg::word_t  wr_data,
    input  wire                  rd_en,
    input  wire pfa_pkg::bank_addr_t rd_addr,
    output pfa_pkg::word_t       rd_data
);
    import pfa_pkg::*;

    word_t mem [BANK_DEPTH];
    word_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- design/pfa_merge.sv -----
// Joins the two words around an element: extracts it for a read, inserts it for a write.
`timescale 1ns / 1ps
`default_nettype none
module pfa_merge (
    input  wire pfa_pkg::acc_info_t info,
    input  wire pfa_pkg::word_t     even_word,
    input  wire pfa_pkg::word_t     odd_word,
    output pfa_pkg::elem_t          read_value,
    output pfa_pkg::word_t          new_even,
    output pfa_pkg::word_t          new_odd
);
    import pfa_pkg::*;

    logic [2*WORD_BITS-1:0] joined;
    logic [2*WORD_BITS-1:0] shifted;
    logic [2*WORD_BITS-1:0] elem_mask;
    logic [2*WORD_BITS-1:0] updated;
    word_t                  lo_word;
    word_t                  hi_word;

    // Order the two words as low then high
    assign lo_word = info.lo_odd ? odd_word  : even_word;
    assign hi_word = info.lo_odd ? even_word : odd_word;
    assign joined  = {hi_word, lo_word};

    // Extract
    assign shifted    = joined >> info.offset;
    assign read_value = info.in_range ? shifted[ELEMENT_BITS-1:0] : '0;

    // Insert
    assign elem_mask = {{(2*WORD_BITS-ELEMENT_BITS){1'b0}}, {ELEMENT_BITS{1'b1}}}
                       << info.offset;
    assign updated   = (joined & ~elem_mask)
                     | ({{(2*WORD_BITS-ELEMENT_BITS){1'b0}}, info.value} << info.offset);

    // Put the updated words back in bank order
    assign new_even = info.lo_odd ? updated[2*WORD_BITS-1:WORD_BITS]
                                  : updated[WORD_BITS-1:0];
    assign new_odd  = info.lo_odd ? updated[WORD_BITS-1:0]
                                  : updated[2*WORD_BITS-1:WORD_BITS];

endmodule
`default_nettype wire

// ----- tb/sv/tb_packed_field_array.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the packed field array: a directed table, then random traffic.
module tb_packed_field_array;
    import pfa_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 8;
    localparam int RANDOM_WORDS = 450;   // per idling phase, three phases
    localparam int ROWS         = 24;

    typedef logic [2*WORD_BITS-1:0] word_pair_t;

    // One row of the directed table; want is only used when typed is set
    typedef struct packed {
        logic             func;
        logic [11:0]      idx;
        elem_t            value;
        logic             typed;
        elem_t            want;
    } probe_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_func        = FUNC_READ;
    logic [11:0]       s_elem_index  = '0;
    elem_t             s_write_value = '0;
    logic              m_ready       = 1'b0;
    logic              s_ready;
    logic              m_valid;
    elem_t             m_read_value;

    // Shadow copy of the word store and the reads still owed by the block
    word_t             word_image [WORD_COUNT];
    elem_t             pending_reads [$];

    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                errors        = 0;
    int                cycle_count   = 0;
    int                reads_sent    = 0;
    int                writes_sent   = 0;
    int                straddles     = 0;
    int                reads_checked = 0;
    logic [11:0]       hot_base      = '0;
    logic [11:0]       last_index    = '0;

    int                send_idle_plan [3] = '{18, 85, 0};
    int                recv_idle_plan [3] = '{85, 18, 0};

    // Directed part: empty store, extremes, straddling elements, back-to-back hazards
    probe_t directed_rows [ROWS] = '{
        '{FUNC_READ,  12'd0,    5'd0,  1'b1, 5'd0},
        '{FUNC_READ,  12'd4095, 5'd0,  1'b1, 5'd0},
        '{FUNC_READ,  12'd6,    5'd0,  1'b1, 5'd0},
        '{FUNC_WRITE, 12'd0,    5'd31, 1'b0, 5'd0},
        '{FUNC_READ,  12'd0,    5'd0,  1'b1, 5'd31},
        '{FUNC_WRITE, 12'd6,    5'd21, 1'b0, 5'd0},
        '{FUNC_READ,  12'd6,    5'd0,  1'b1, 5'd21},
        '{FUNC_READ,  12'd5,    5'd31, 1'b0, 5'd0},
        '{FUNC_READ,  12'd7,    5'd0,  1'b0, 5'd0},
        '{FUNC_WRITE, 12'd4095, 5'd31, 1'b0, 5'd0},
        '{FUNC_READ,  12'd4095, 5'd0,  1'b1, 5'd31},
        '{FUNC_READ,  12'd4094, 5'd0,  1'b0, 5'd0},
        '{FUNC_WRITE, 12'd1,    5'd0,  1'b0, 5'd0},
        '{FUNC_READ,  12'd1,    5'd0,  1'b1, 5'd0},
        '{FUNC_WRITE, 12'd12,   5'd10, 1'b0, 5'd0},
        '{FUNC_WRITE, 12'd13,   5'd31, 1'b0, 5'd0},
        '{FUNC_READ,  12'd12,   5'd0,  1'b0, 5'd0},
        '{FUNC_READ,  12'd13,   5'd0,  1'b0, 5'd0},
        '{FUNC_WRITE, 12'd2048, 5'd16, 1'b0, 5'd0},
        '{FUNC_READ,  12'd2048, 5'd0,  1'b1, 5'd16},
        '{FUNC_WRITE, 12'd6,    5'd0,  1'b0, 5'd0},
        '{FUNC_READ,  12'd6,    5'd0,  1'b1, 5'd0},
        '{FUNC_WRITE, 12'd25,   5'd17, 1'b0, 5'd0},
        '{FUNC_READ,  12'd25,   5'd0,  1'b0, 5'd0}
    };

    packed_field_array dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_elem_index  (s_elem_index),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value)
    );

    always #10 aclk = ~aclk;

    // Element as held in the shadow store; the spare word keeps w+1 in bounds
    function automatic elem_t fetch_element(logic [11:0] idx);
        int unsigned bitpos;
        int unsigned w;
        word_pair_t  pair;
        if (idx >= ELEMENT_COUNT)
            return '0;
        bitpos = int'(idx) * ELEMENT_BITS;
        w      = bitpos / WORD_BITS;
        pair   = {word_image[w+1], word_image[w]};
        return elem_t'(pair >> (bitpos % WORD_BITS));
    endfunction

    // Read-modify-write of the one or two words an element covers
    function automatic void store_element(logic [11:0] idx, elem_t value);
        int unsigned bitpos;
        int unsigned w;
        int unsigned r;
        word_pair_t  pair;
        word_pair_t  mask;
        if (idx >= ELEMENT_COUNT)
            return;
        bitpos = int'(idx) * ELEMENT_BITS;
        w      = bitpos / WORD_BITS;
        r      = bitpos % WORD_BITS;
        pair   = {word_image[w+1], word_image[w]};
        mask   = word_pair_t'({ELEMENT_BITS{1'b1}}) << r;
        pair   = (pair & ~mask) | (word_pair_t'(value) << r);
        word_image[w]   = pair[WORD_BITS-1:0];
        word_image[w+1] = pair[2*WORD_BITS-1:WORD_BITS];
    endfunction

    function automatic bit element_straddles(logic [11:0] idx);
        return ((int'(idx) * ELEMENT_BITS) % WORD_BITS) + ELEMENT_BITS > WORD_BITS;
    endfunction

    // Offer one word, hold it until accepted, then update the prediction
    task automatic send_word(logic func, logic [11:0] idx, elem_t value,
                             logic typed, elem_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= func;
        s_elem_index  <= idx;
        s_write_value <= value;
        @(posedge aclk);
        while (s_ready !== 1'b1)
            @(posedge aclk);
        if (func == FUNC_READ) begin
            pending_reads.push_back(typed ? want : fetch_element(idx));
            reads_sent++;
        end else begin
            store_element(idx, value);
            writes_sent++;
        end
        if (element_straddles(idx))
            straddles++;
    endtask

    // Random word: clustered indices half the time so reads land on recent writes
    task automatic send_random_word();
        logic [11:0] idx;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            idx = 12'($urandom_range(4095));
        end else if (pick < 60) begin
            idx = hot_base + 12'($urandom_range(15));
        end else if (pick < 80) begin
            idx = 12'($urandom_range(4095));
            while (!element_straddles(idx))
                idx = 12'($urandom_range(4095));
        end else begin
            idx = last_index;
        end
        if ($urandom_range(15) == 0)
            hot_base = 12'($urandom_range(4095));
        send_word($urandom_range(1) ? FUNC_WRITE : FUNC_READ, idx,
                  elem_t'($urandom_range(31)), 1'b0, '0);
        last_index = idx;
    endtask

    // Result side: random back-pressure and the comparison
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_reads.size() == 0) begin
                $display("%0t: read word with no request pending, got %0d",
                         $time, m_read_value);
                errors++;
            end else begin
                if (m_read_value !== pending_reads[0]) begin
                    $display("%0t: read_value mismatch, expected %0d, got %0d",
                             $time, pending_reads[0], m_read_value);
                    errors++;
                end
                void'(pending_reads.pop_front());
                reads_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reads outstanding",
                     cycle_count, pending_reads.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int row;
        int phase;
        foreach (word_image[i])
            word_image[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table under the first idling mix
        send_idle_pct = send_idle_plan[0];
        recv_idle_pct = recv_idle_plan[0];
        for (row = 0; row < ROWS; row++)
            send_word(directed_rows[row].func, directed_rows[row].idx,
                      directed_rows[row].value, directed_rows[row].typed,
                      directed_rows[row].want);

        // Random traffic through each idling mix
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = send_idle_plan[phase];
            recv_idle_pct = recv_idle_plan[phase];
            repeat (RANDOM_WORDS)
                send_random_word();
        end
        s_valid <= 1'b0;

        // Drain outstanding reads, then let the pipeline settle
        while (pending_reads.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d reads and %0d writes, %0d of them on straddling elements",
                 reads_sent, writes_sent, straddles);
        $display("%0d read words checked, %0d errors", reads_checked, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/pfa_pkg.sv
design/pfa_bank.sv
design/pfa_merge.sv
design/packed_field_array.sv
tb/sv/tb_packed_field_array.sv
